// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// dq_pkg: field widths, opcode and status codes, control and status structs
// shared by the deque controller, datapath and channel interfaces
// no dependencies
package dq_pkg;

	localparam int OPCODE_W   = 3;
	localparam int DATA_IN_W  = 32;
	localparam int DATA_OUT_W = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 6;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP_FWD   = 3'd4,
		OP_DUMP_BWD   = 3'd5
	} dq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK    = 2'd0,
		RES_EMPTY = 2'd1,
		RES_FULL  = 2'd2
	} dq_status_t;

	// controller to datapath
	typedef struct packed {
		logic       take;      // capture the incoming item
		logic       push;      // store data and move the pointers
		logic       read;      // issue a ring read, pops also move the pointers
		logic       load;      // load the result register
		logic       from_ram;  // result data from the ring read port
		logic       last;
		dq_status_t status;
	} dq_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_push;
		logic is_pop;
		logic is_dump;
		logic empty;
		logic full;
		logic dump_done;
	} dq_sts_t;

endpackage

// ----- hw/rtl/dq_if.sv -----
`timescale 1ns / 1ps
// dq_if: valid/ready channel interfaces for deque commands and results
// depends on dq_pkg
interface dq_cmd_if;
	import dq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [OPCODE_W-1:0]         opcode;
	logic signed [DATA_IN_W-1:0] data_in;

	modport source (output valid, opcode, data_in, input ready);
	modport sink (input valid, opcode, data_in, output ready);
endinterface

interface dq_res_if;
	import dq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [STATUS_W-1:0]          status;
	logic signed [DATA_OUT_W-1:0] data_out;
	logic [COUNT_W-1:0]           element_count;
	logic                         last;

	modport source (output valid, status, data_out, element_count, last, input ready);
	modport sink (input valid, status, data_out, element_count, last, output ready);
endinterface

// ----- hw/rtl/dq_ram.sv -----
`timescale 1ns / 1ps
// dq_ram: generic single write port, single read port ram with registered read
// no dependencies
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ----- hw/rtl/dq_dp.sv -----
`timescale 1ns / 1ps
// dq_dp: deque datapath, ring pointers, ring ram, dump counter, result register
// depends on dq_pkg and dq_ram
module dq_dp #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dq_pkg::dq_ctl_t                      ctl,
	output dq_pkg::dq_sts_t                      sts,
	input  logic [dq_pkg::OPCODE_W-1:0]          in_opcode,
	input  logic signed [dq_pkg::DATA_IN_W-1:0]  in_data,
	output logic [dq_pkg::STATUS_W-1:0]          res_status,
	output logic signed [dq_pkg::DATA_OUT_W-1:0] res_data,
	output logic [dq_pkg::COUNT_W-1:0]           res_count,
	output logic                                 res_last
);
	import dq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = IW + 1;

	logic [OPCODE_W-1:0]   op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [IW-1:0]         head_q;
	logic [CW-1:0]         occ_q;
	logic [CW-1:0]         cnt_q;

	logic [STATUS_W-1:0]   status_q;
	logic [DATA_OUT_W-1:0] data_out_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  last_q;

	logic [IW-1:0]         head_dec;
	logic [IW-1:0]         head_inc;
	logic [IW-1:0]         wr_addr;
	logic [IW-1:0]         rd_addr;
	logic [CW-1:0]         occ_m1;
	logic [CW-1:0]         rd_off;
	logic [CW-1:0]         res_occ;
	logic [DATA_WIDTH-1:0] rd_data;

	logic [DATA_IN_W+DATA_WIDTH-1:0]  in_ext;
	logic [DATA_OUT_W+DATA_WIDTH-1:0] out_ext;
	logic [COUNT_W+CW-1:0]            count_ext;

	// head plus offset, wrapped into the ring
	function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign in_ext = {{DATA_WIDTH{1'b0}}, $unsigned(in_data)};

	always_comb begin
		sts.is_push   = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
		sts.is_pop    = (op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK);
		sts.is_dump   = (op_q == OP_DUMP_FWD) || (op_q == OP_DUMP_BWD);
		sts.empty     = (occ_q == '0);
		sts.full      = (occ_q == CW'(DEPTH));
		sts.dump_done = (cnt_q == occ_q);
	end

	assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = ring_slot(head_q, CW'(1));
	assign occ_m1   = occ_q - 1'b1;
	assign wr_addr  = (op_q == OP_PUSH_FRONT) ? head_dec : ring_slot(head_q, occ_q);

	always_comb begin
		case (op_q)
			OP_POP_FRONT: rd_off = '0;
			OP_POP_BACK:  rd_off = occ_m1;
			OP_DUMP_FWD:  rd_off = cnt_q;
			OP_DUMP_BWD:  rd_off = occ_m1 - cnt_q;
			default:      rd_off = '0;
		endcase
	end

	assign rd_addr = ring_slot(head_q, rd_off);

	dq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ctl.push),
		.wr_addr (wr_addr),
		.wr_data (data_q),
		.rd_en   (ctl.read),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// captured item, no reset
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q   <= in_opcode;
			data_q <= in_ext[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.take) begin
				cnt_q <= '0;
			end
			if (ctl.push) begin
				occ_q <= occ_q + 1'b1;
				if (op_q == OP_PUSH_FRONT) begin
					head_q <= head_dec;
				end
			end
			if (ctl.read) begin
				cnt_q <= cnt_q + 1'b1;
				if (op_q == OP_POP_FRONT) begin
					head_q <= head_inc;
					occ_q  <= occ_m1;
				end else if (op_q == OP_POP_BACK) begin
					occ_q <= occ_m1;
				end
			end
		end
	end

	assign res_occ   = ctl.push ? occ_q + 1'b1 : occ_q;
	assign out_ext   = {{DATA_OUT_W{1'b0}}, rd_data};
	assign count_ext = {{COUNT_W{1'b0}}, res_occ};

	// result register, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status_q   <= ctl.status;
			data_out_q <= ctl.from_ram ? out_ext[DATA_OUT_W-1:0] : '0;
			count_q    <= count_ext[COUNT_W-1:0];
			last_q     <= ctl.last;
		end
	end

	assign res_status = status_q;
	assign res_data   = $signed(data_out_q);
	assign res_count  = count_q;
	assign res_last   = last_q;
endmodule

// ----- hw/rtl/dq_ctrl.sv -----
`timescale 1ns / 1ps
// dq_ctrl: deque controller, sequences pushes, pops and dumps
// depends on dq_pkg
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  dq_pkg::dq_sts_t sts,
	output dq_pkg::dq_ctl_t ctl
);
	import dq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   res_valid_q;
	logic   res_valid_nxt;
	logic   out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		ctl       = '0;
		ctl.status = RES_OK;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				ctl.take = cmd_valid;
				if (cmd_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_push) begin
					if (out_free) begin
						ctl.load   = 1'b1;
						ctl.last   = 1'b1;
						ctl.push   = !sts.full;
						ctl.status = sts.full ? RES_FULL : RES_OK;
						state_nxt  = S_IDLE;
					end
				end else if (sts.is_pop || sts.is_dump) begin
					if (sts.empty) begin
						if (out_free) begin
							ctl.load   = 1'b1;
							ctl.last   = 1'b1;
							ctl.status = RES_EMPTY;
							state_nxt  = S_IDLE;
						end
					end else begin
						ctl.read  = 1'b1;
						state_nxt = S_READ;
					end
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					ctl.load     = 1'b1;
					ctl.from_ram = 1'b1;
					ctl.last     = sts.is_pop || sts.dump_done;
					if (sts.is_pop || sts.dump_done) begin
						state_nxt = S_IDLE;
					end else begin
						ctl.read = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (ctl.load) begin
			res_valid_nxt = 1'b1;
		end else if (res_ready) begin
			res_valid_nxt = 1'b0;
		end else begin
			res_valid_nxt = res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= res_valid_nxt;
		end
	end
endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// double_ended_queue: bounded deque of signed values kept in a ring ram
// usage:
//   cmd carries opcode and data_in; a transfer happens when valid and ready are high
//   res carries status, data_out, element_count and last, one transfer per result
//   push front/back, pop front/back give one result each; a dump gives one result
//   per held element (last on the final one), or a single empty result
// sequencing:
//   push or refused/empty op: result loaded in S_EXEC once the output register is free
//   pop: ring read issued in S_EXEC, result loaded from the registered read in S_READ
//   dump of n elements: first result loaded in S_READ, then one per cycle
//   while the output register is free; cmd ready is high only while the
//   controller is idle, so a new cmd is taken once the previous one is done
//   an unknown opcode is taken and dropped without a result
// reset: arst_n clears the pointers, occupancy and the result valid; ring contents
//   are left as they are and are never read before written
// back-pressure: a result waits in the output register while res ready is low;
//   the next cmd can still be taken and is held until the register frees up
module double_ended_queue #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	dq_cmd_if.sink   cmd,
	dq_res_if.source res
);
	import dq_pkg::*;

	// command and status between controller and datapath
	dq_ctl_t ctl;
	dq_sts_t sts;

	// controller: sequencing and result valid
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// datapath: ring ram, head and occupancy, result payload
	dq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_opcode  (cmd.opcode),
		.in_data    (cmd.data_in),
		.res_status (res.status),
		.res_data   (res.data_out),
		.res_count  (res.element_count),
		.res_last   (res.last)
	);
endmodule

// ----- verif/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// tb_double_ended_queue: self-checking testbench for the double_ended_queue block
// depends on dq_pkg, dq_cmd_if, dq_res_if and the double_ended_queue rtl
// a directed table and random command streams, results checked against a ring predictor or typed rows
module tb_double_ended_queue;
	import dq_pkg::*;

	localparam int DEPTH           = 32;
	localparam int CLK_HIGH        = 6;
	localparam int CLK_LOW         = 6;
	localparam int RESET_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_CYCLES     = 250;
	localparam int SETTLE_CYCLES   = 40;
	localparam int ITEMS_PER_PHASE = 22;

	// opcodes the block takes and drops without a result
	localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

	typedef struct packed {
		dq_status_t            status;
		logic [DATA_OUT_W-1:0] data_out;
		logic [COUNT_W-1:0]    element_count;
		logic                  last;
	} deque_result_t;

	// one row of the directed table; the expected fields only count when typed is set
	typedef struct packed {
		logic [OPCODE_W-1:0]  op;
		logic [DATA_IN_W-1:0] value;
		logic [5:0]           reps;
		logic                 rand_value;
		logic                 typed;
		dq_status_t           status;
		logic [DATA_OUT_W-1:0] data_out;
		logic [COUNT_W-1:0]   element_count;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 24;

	directed_row_t directed_table [0:DIRECTED_ROWS-1] = '{
		// every pop and dump on an empty deque answers empty
		'{OP_POP_FRONT,  32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_EMPTY, 32'h0, 6'd0},
		'{OP_POP_BACK,   32'h5a5a_5a5a, 6'd1, 1'b0, 1'b1, RES_EMPTY, 32'h0, 6'd0},
		'{OP_DUMP_FWD,   32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_EMPTY, 32'h0, 6'd0},
		'{OP_DUMP_BWD,   32'hffff_ffff, 6'd1, 1'b0, 1'b1, RES_EMPTY, 32'h0, 6'd0},
		'{OP_UNUSED_6,   32'hffff_ffff, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		// extremes of the value pushed at both ends
		'{OP_PUSH_BACK,  32'h7fff_ffff, 6'd1, 1'b0, 1'b1, RES_OK,    32'h0, 6'd1},
		'{OP_PUSH_FRONT, 32'h8000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'h0, 6'd2},
		'{OP_PUSH_BACK,  32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'h0, 6'd3},
		'{OP_PUSH_FRONT, 32'hffff_ffff, 6'd1, 1'b0, 1'b1, RES_OK,    32'h0, 6'd4},
		'{OP_DUMP_FWD,   32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_DUMP_BWD,   32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_POP_FRONT,  32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'hffff_ffff, 6'd3},
		'{OP_POP_BACK,   32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'h0, 6'd2},
		'{OP_UNUSED_7,   32'h1234_5678, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_POP_FRONT,  32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'h8000_0000, 6'd1},
		'{OP_POP_BACK,   32'h0000_0000, 6'd1, 1'b0, 1'b1, RES_OK,    32'h7fff_ffff, 6'd0},
		// fill from both ends so the head wraps below entry zero
		'{OP_PUSH_FRONT, 32'h0000_0000, 6'd16, 1'b1, 1'b0, RES_OK,   32'h0, 6'd0},
		'{OP_PUSH_BACK,  32'h0000_0000, 6'd16, 1'b1, 1'b0, RES_OK,   32'h0, 6'd0},
		// pushes on a full deque are refused
		'{OP_PUSH_FRONT, 32'h0000_ffff, 6'd1, 1'b0, 1'b1, RES_FULL,  32'h0, 6'd32},
		'{OP_PUSH_BACK,  32'hffff_0000, 6'd1, 1'b0, 1'b1, RES_FULL,  32'h0, 6'd32},
		// longest dumps, every element in both directions
		'{OP_DUMP_FWD,   32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_DUMP_BWD,   32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_POP_FRONT,  32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0},
		'{OP_POP_BACK,   32'h0000_0000, 6'd1, 1'b0, 1'b0, RES_OK,    32'h0, 6'd0}
	};

	logic clk;
	logic arst_n;

	dq_cmd_if cmd_ch ();
	dq_res_if res_ch ();

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_IN_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// predictor state: its own ring, front index and fill level
	logic [DATA_IN_W-1:0] deque_ring [0:DEPTH-1];
	int                   deque_head;
	int                   deque_count;

	// results of the latest predicted command, and every result still owed by the block
	deque_result_t predicted_results [$];
	deque_result_t owed_results [$];
	deque_result_t oldest_owed;

	// idling percentages per side, and a long receiver hold-off counted down by the receiver
	int src_idle_pct;
	int sink_idle_pct;
	int hold_cycles;

	// random stream drifts between filling and draining so both ends of the range are reached
	bit growing;

	int cycle_count;
	int mismatch_count;
	int commands_sent;
	int results_checked;
	int full_seen;
	int empty_seen;

	int                   row_idx;
	int                   rep_idx;
	logic [DATA_IN_W-1:0] row_value;

	function automatic deque_result_t make_result(input dq_status_t st,
			input logic [DATA_OUT_W-1:0] d, input int cnt, input logic lst);
		deque_result_t r;
		r.status        = st;
		r.data_out      = d;
		r.element_count = COUNT_W'(cnt);
		r.last          = lst;
		return r;
	endfunction

	// works out what the block answers to one command and moves the ring state on
	task automatic predict_deque(input logic [OPCODE_W-1:0] op, input logic [DATA_IN_W-1:0] val);
		int                   idx;
		logic [DATA_IN_W-1:0] popped;
		predicted_results.delete();
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (deque_count >= DEPTH) begin
					predicted_results.push_back(make_result(RES_FULL, '0, deque_count, 1'b1));
				end else begin
					if (op == OP_PUSH_FRONT) begin
						deque_head = (deque_head + DEPTH - 1) % DEPTH;
						deque_ring[deque_head] = val;
					end else begin
						deque_ring[(deque_head + deque_count) % DEPTH] = val;
					end
					deque_count++;
					predicted_results.push_back(make_result(RES_OK, '0, deque_count, 1'b1));
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (deque_count == 0) begin
					predicted_results.push_back(make_result(RES_EMPTY, '0, 0, 1'b1));
				end else begin
					if (op == OP_POP_FRONT) begin
						popped = deque_ring[deque_head];
						deque_head = (deque_head + 1) % DEPTH;
					end else begin
						popped = deque_ring[(deque_head + deque_count - 1) % DEPTH];
					end
					deque_count--;
					predicted_results.push_back(make_result(RES_OK, popped, deque_count, 1'b1));
				end
			end
			OP_DUMP_FWD, OP_DUMP_BWD: begin
				if (deque_count == 0) begin
					predicted_results.push_back(make_result(RES_EMPTY, '0, 0, 1'b1));
				end else begin
					for (int i = 0; i < deque_count; i++) begin
						if (op == OP_DUMP_FWD)
							idx = (deque_head + i) % DEPTH;
						else
							idx = (deque_head + deque_count - 1 - i) % DEPTH;
						predicted_results.push_back(make_result(RES_OK, deque_ring[idx],
							deque_count, (i == deque_count - 1)));
					end
				end
			end
			default: begin
				// unused opcodes leave no trace
			end
		endcase
	endtask

	// offers one command, waits for its transfer, then records what it is owed
	task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [DATA_IN_W-1:0] val,
			input logic typed, input deque_result_t typed_result);
		// random idle cycles before the offer, valid low meanwhile
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.data_in <= val;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		predict_deque(op, val);
		if (typed)
			owed_results.push_back(typed_result);
		else
			foreach (predicted_results[i])
				owed_results.push_back(predicted_results[i]);
		commands_sent++;
	endtask

	// random commands with random content; ignored opcodes are sent but not counted
	task automatic run_random(input int n);
		int                   issued;
		int                   pick;
		logic [OPCODE_W-1:0]  op;
		logic [DATA_IN_W-1:0] val;
		issued = 0;
		while (issued < n) begin
			if (growing && deque_count == DEPTH && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && deque_count == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
			else if (pick < 15)
				op = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BWD;
			else if ((pick < 78) == growing)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			case ($urandom_range(0, 39))
				0:       val = 32'h7fff_ffff;
				1:       val = 32'h8000_0000;
				2:       val = 32'h0000_0000;
				3:       val = 32'hffff_ffff;
				default: val = $urandom;
			endcase
			send_command(op, val, 1'b0, '0);
			if (op != OP_UNUSED_6 && op != OP_UNUSED_7)
				issued++;
		end
	endtask

	// sender goes quiet until every owed result has been transferred
	task automatic pause_until_drained();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_results.size() != 0);
	endtask

	initial clk = 1'b0;

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	// receiver: one ready decision per edge, or a long hold-off while hold_cycles runs down
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			res_ch.ready <= 1'b0;
			hold_cycles  <= hold_cycles - 1;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// result checker: every result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (owed_results.size() == 0) begin
				$error("result transfer with nothing owed: status %0d data_out %0h count %0d",
					res_ch.status, res_ch.data_out, res_ch.element_count);
				mismatch_count++;
			end else begin
				oldest_owed = owed_results.pop_front();
				results_checked++;
				if (oldest_owed.status == RES_FULL)
					full_seen++;
				if (oldest_owed.status == RES_EMPTY)
					empty_seen++;
				if (res_ch.status !== oldest_owed.status) begin
					$error("status: expected %0d, actual %0d", oldest_owed.status, res_ch.status);
					mismatch_count++;
				end
				if (res_ch.data_out !== oldest_owed.data_out) begin
					$error("data_out: expected %0h, actual %0h",
						oldest_owed.data_out, res_ch.data_out);
					mismatch_count++;
				end
				if (res_ch.element_count !== oldest_owed.element_count) begin
					$error("element_count: expected %0d, actual %0d",
						oldest_owed.element_count, res_ch.element_count);
					mismatch_count++;
				end
				if (res_ch.last !== oldest_owed.last) begin
					$error("last: expected %0d, actual %0d", oldest_owed.last, res_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	// overall watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout with %0d results still owed", owed_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.opcode  = OP_PUSH_FRONT;
		cmd_ch.data_in = '0;
		res_ch.ready   = 1'b0;
		deque_head     = 0;
		deque_count    = 0;
		growing        = 1'b0;
		hold_cycles    = 0;
		cycle_count    = 0;
		mismatch_count = 0;
		commands_sent  = 0;
		results_checked = 0;
		full_seen      = 0;
		empty_seen     = 0;
		// sender rarely idles, receiver often stalls
		src_idle_pct   = 6;
		sink_idle_pct  = 64;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed rows carry their own expectation, the rest use the predictor
		for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++) begin
			for (rep_idx = 0; rep_idx < directed_table[row_idx].reps; rep_idx++) begin
				row_value = directed_table[row_idx].rand_value ? $urandom
					: directed_table[row_idx].value;
				send_command(directed_table[row_idx].op, row_value,
					directed_table[row_idx].typed,
					make_result(directed_table[row_idx].status,
						directed_table[row_idx].data_out,
						directed_table[row_idx].element_count, 1'b1));
			end
		end
		run_random(ITEMS_PER_PHASE);
		pause_until_drained();

		// now the sender idles often and the receiver rarely
		src_idle_pct  = 64;
		sink_idle_pct = 6;
		run_random(ITEMS_PER_PHASE);
		pause_until_drained();

		// no idling, but open with a long receiver hold-off so the block backs up
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_cycles   = HOLD_CYCLES;
		run_random(ITEMS_PER_PHASE);
		cmd_ch.valid <= 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		// let a late or surplus result show itself
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d command transfers and %0d result transfers (%0d full, %0d empty)",
			commands_sent, results_checked, full_seen, empty_seen);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
